/* design/ssdb_pkg.sv */
// shared types, constants and tables for the seven-segment digit buffer
package ssdb_pkg;

    localparam int DIGIT_COUNT_DEF = 4;
    localparam int MAX_DIGITS      = 8;
    localparam int POW_W           = 27;

    localparam logic [7:0] CONTROL_BYTE = 8'h01;
    localparam logic [7:0] MINUS_SEGS   = 8'h40;
    localparam logic [7:0] DOT_BIT      = 8'h80;

    typedef enum logic [2:0] {
        K_NUMBER      = 3'd0,
        K_DIGIT       = 3'd1,
        K_DOT         = 3'd2,
        K_MINUS       = 3'd3,
        K_RAW         = 3'd4,
        K_CLEAR_ALL   = 3'd5,
        K_CLEAR_DIGIT = 3'd6,
        K_SEND        = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SEND
    } state_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_SEGS,
        ST_BYTE,
        ST_DOT,
        ST_CLEAR
    } store_op_t;

    typedef struct packed {
        store_op_t   op;
        logic [2:0]  idx;
        logic [7:0]  data;
        logic        hit;
    } store_req_t;

    typedef struct packed {
        logic load;
        logic sub;
        logic next_digit;
    } unit_ctl_t;

    localparam logic [7:0] GLYPHS [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    localparam logic [6:0] ADDRESSES [0:3] = '{7'h38, 7'h39, 7'h40, 7'h41};

    localparam logic [POW_W-1:0] POW10 [0:8] = '{
        27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000,
        27'd1000000, 27'd10000000, 27'd100000000
    };

endpackage

/* design/ssdb_digit_unit.sv */
// shared compare-and-subtract unit that peels off one decimal digit at a time
module ssdb_digit_unit
    import ssdb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  unit_ctl_t        ctl,
    input  logic [15:0]      load_value,
    input  logic [POW_W-1:0] weight,
    output logic             ge,
    output logic [3:0]       digit
);

    logic [15:0] rem_reg, rem_next;
    logic [3:0]  cnt_reg, cnt_next;

    assign ge    = {{(POW_W-16){1'b0}}, rem_reg} >= weight;
    assign digit = (cnt_reg > 4'd9) ? 4'd9 : cnt_reg;

    always_comb
    begin
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctl.load)
        begin
            rem_next = load_value;
            cnt_next = 4'd0;
        end
        else if (ctl.sub)
        begin
            // weight never exceeds the remainder here, so the low bits suffice
            rem_next = rem_reg - weight[15:0];
            cnt_next = cnt_reg + 4'd1;
        end
        else if (ctl.next_digit)
        begin
            cnt_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

/* design/ssdb_store.sv */
// segment byte per digit, with dot handling and a single read port
module ssdb_store
    import ssdb_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    parameter int IW          = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  store_req_t    req,
    input  logic [IW-1:0] rd_idx,
    output logic [7:0]    rd_data
);

    logic [7:0]    seg_reg [DIGIT_COUNT];
    logic [IW-1:0] widx;

    assign widx    = req.idx[IW-1:0];
    assign rd_data = seg_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                seg_reg[i] <= 8'h00;
            end
        end
        else
        begin
            case (req.op)
                ST_SEGS:
                begin
                    seg_reg[widx] <= (req.data & ~DOT_BIT) | (seg_reg[widx] & DOT_BIT);
                end
                ST_BYTE:
                begin
                    seg_reg[widx] <= req.data;
                end
                ST_DOT:
                begin
                    // one dot at most; a miss clears them all
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        seg_reg[i][7] <= req.hit && (IW'(i) == widx);
                    end
                end
                ST_CLEAR:
                begin
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        seg_reg[i] <= 8'h00;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* design/seven_segment_digit_buffer_unit.sv */
// top level: command sequencer, decimal conversion and frame sender
// digit, dot, minus, raw and clear commands take effect in the accept cycle
// a number is converted digit by digit through repeated subtraction, all nines when
// too large; a send gives the control byte and then the digit bytes,
// one byte per cycle, with the strobe registered from the send state; the receiver cannot stall
// reset clears the digits to blank, device select to 0 and the sequencer to idle
module seven_segment_digit_buffer_unit
    import ssdb_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [2:0]  position,
    input  logic [15:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    output logic        strobe,
    output logic [6:0]  bus_address,
    output logic [7:0]  frame_byte,
    output logic        last
);

    localparam int IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CW = $clog2(DIGIT_COUNT + 1);
    localparam logic [POW_W:0] LIMIT = {1'b0, POW10[DIGIT_COUNT]};

    state_t        state_reg, state_next;
    logic [1:0]    dev_reg;
    logic [IW-1:0] digit_idx_reg, digit_idx_next;
    logic [CW-1:0] send_cnt_reg, send_cnt_next;
    logic          ovf_reg, ovf_next;
    logic          strobe_reg, last_reg;
    logic [7:0]    byte_reg;
    logic [6:0]    addr_reg;

    logic          accept;
    logic          in_range;
    logic          digit_done;
    logic [3:0]    pow_idx;
    logic [3:0]    clamped;
    logic          ge;
    logic [3:0]    digit;
    logic [7:0]    rd_data;
    logic [IW-1:0] rd_idx;
    store_req_t    req;
    unit_ctl_t     ctl;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = {1'b0, position} < 4'(DIGIT_COUNT);
    assign clamped   = (value[7:0] > 8'd9) ? 4'd9 : value[3:0];
    assign pow_idx   = 4'(DIGIT_COUNT - 1) - 4'(digit_idx_reg);
    assign digit_done = ovf_reg || !ge;
    assign rd_idx    = IW'(send_cnt_reg - CW'(1));

    ssdb_digit_unit u_digit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .load_value (value),
        .weight     (POW10[pow_idx]),
        .ge         (ge),
        .digit      (digit)
    );

    ssdb_store #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .IW          (IW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next     = state_reg;
        digit_idx_next = digit_idx_reg;
        send_cnt_next  = send_cnt_reg;
        ovf_next       = ovf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && kind == K_NUMBER)
                begin
                    state_next     = S_CONV;
                    digit_idx_next = '0;
                    ovf_next       = {{(POW_W-15){1'b0}}, value} >= LIMIT;
                end
                else if (accept && kind == K_SEND)
                begin
                    state_next    = S_SEND;
                    send_cnt_next = '0;
                end
            end
            S_CONV:
            begin
                if (digit_done)
                begin
                    digit_idx_next = digit_idx_reg + IW'(1);
                    if (digit_idx_reg == IW'(DIGIT_COUNT - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SEND:
            begin
                send_cnt_next = send_cnt_reg + CW'(1);
                if (send_cnt_reg == CW'(DIGIT_COUNT))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs to the store and the digit unit
    always_comb
    begin
        req  = '{op: ST_NONE, idx: position, data: 8'h00, hit: in_range};
        ctl  = '{load: 1'b0, sub: 1'b0, next_digit: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        K_NUMBER:
                        begin
                            ctl.load = 1'b1;
                        end
                        K_DIGIT:
                        begin
                            req.op   = in_range ? ST_SEGS : ST_NONE;
                            req.data = GLYPHS[clamped];
                        end
                        K_DOT:
                        begin
                            req.op = ST_DOT;
                        end
                        K_MINUS:
                        begin
                            req.op   = in_range ? ST_SEGS : ST_NONE;
                            req.data = MINUS_SEGS;
                        end
                        K_RAW:
                        begin
                            req.op   = in_range ? ST_BYTE : ST_NONE;
                            req.data = value[7:0];
                        end
                        K_CLEAR_ALL:
                        begin
                            req.op = ST_CLEAR;
                        end
                        K_CLEAR_DIGIT:
                        begin
                            req.op = in_range ? ST_BYTE : ST_NONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                req.idx = 3'(digit_idx_reg);
                if (ovf_reg)
                begin
                    req.op   = ST_SEGS;
                    req.data = GLYPHS[9];
                end
                else if (ge)
                begin
                    ctl.sub = 1'b1;
                end
                else
                begin
                    req.op         = ST_SEGS;
                    req.data       = GLYPHS[digit];
                    ctl.next_digit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dev_reg       <= 2'd0;
            digit_idx_reg <= '0;
            send_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_idx_reg <= digit_idx_next;
            send_cnt_reg  <= send_cnt_next;
            ovf_reg       <= ovf_next;
            strobe_reg    <= (state_reg == S_SEND);
            if (cfg_valid && cfg_ready)
            begin
                dev_reg <= cfg_data;
            end
        end
    end

    // frame output register
    always_ff @(posedge clk)
    begin
        addr_reg <= ADDRESSES[dev_reg];
        byte_reg <= (send_cnt_reg == '0) ? CONTROL_BYTE : rd_data;
        last_reg <= (send_cnt_reg == CW'(DIGIT_COUNT));
    end

    assign strobe      = strobe_reg;
    assign bus_address = addr_reg;
    assign frame_byte  = byte_reg;
    assign last        = last_reg;

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == K_SEND) |=> busy)
        else $error("send request did not start the frame");

    a_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(strobe) |-> (frame_byte == CONTROL_BYTE && !last))
        else $error("frame does not open with the control byte");

    a_frame_contig: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a frame");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("strobe continues past the last byte");

endmodule

/* sim/testbench.sv */
// testbench for the seven-segment digit buffer: directed table, random bursts, frame checks
`timescale 1ns / 1ps

module testbench
    import ssdb_pkg::*;
();

    localparam int DIGITS        = 4;
    localparam int SETTLE_CYCLES = 48;
    localparam int RUN_LIMIT     = 400000;

    localparam logic [7:0] SEGS_OF [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };
    localparam logic [6:0] CHIP_ADDR [0:3] = '{7'h38, 7'h39, 7'h40, 7'h41};
    localparam logic [7:0] FRAME_HEAD = 8'h01;

    typedef struct packed {
        logic [6:0] addr;
        logic [7:0] data;
        logic       last;
    } frame_entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  pos;
        logic [15:0] val;
        logic        typed;
        logic [31:0] shown;     // digit bytes 0..3, position 0 in the top byte
    } command_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = 3'd0;
    logic [2:0]  position = 3'd0;
    logic [15:0] value = 16'd0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = 2'd0;
    logic        strobe;
    logic [6:0]  bus_address;
    logic [7:0]  frame_byte;
    logic        last;

    logic [7:0]   digit_bytes [DIGITS];
    logic [1:0]   chip_select;
    frame_entry_t pending_frame [$];

    int errors;
    int commands_issued;
    int sends_issued;
    int bytes_checked;

    seven_segment_digit_buffer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .position    (position),
        .value       (value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .strobe      (strobe),
        .bus_address (bus_address),
        .frame_byte  (frame_byte),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // update the display image and queue the frame a send produces
    task automatic track_command(input command_t c);
        logic [15:0] rest;
        int          d;
        begin
            commands_issued++;
            case (c.kind)
                K_NUMBER:
                begin
                    rest = c.val;
                    for (int i = DIGITS - 1; i >= 0; i--)
                    begin
                        d = (c.val >= 16'd10000) ? 9 : int'(rest % 16'd10);
                        rest = rest / 16'd10;
                        digit_bytes[i] = {digit_bytes[i][7], SEGS_OF[d][6:0]};
                    end
                end
                K_DIGIT:
                    if (c.pos < DIGITS)
                    begin
                        d = (c.val[7:0] > 8'd9) ? 9 : int'(c.val[7:0]);
                        digit_bytes[c.pos] = {digit_bytes[c.pos][7], SEGS_OF[d][6:0]};
                    end
                K_DOT:
                    for (int i = 0; i < DIGITS; i++)
                        digit_bytes[i][7] = (i == c.pos);
                K_MINUS:
                    if (c.pos < DIGITS)
                        digit_bytes[c.pos] = {digit_bytes[c.pos][7], MINUS_SEGS[6:0]};
                K_RAW:
                    if (c.pos < DIGITS)
                        digit_bytes[c.pos] = c.val[7:0];
                K_CLEAR_ALL:
                    for (int i = 0; i < DIGITS; i++)
                        digit_bytes[i] = 8'h00;
                K_CLEAR_DIGIT:
                    if (c.pos < DIGITS)
                        digit_bytes[c.pos] = 8'h00;
                K_SEND:
                begin
                    sends_issued++;
                    pending_frame.push_back('{CHIP_ADDR[chip_select], FRAME_HEAD, 1'b0});
                    for (int i = 0; i < DIGITS; i++)
                        pending_frame.push_back('{CHIP_ADDR[chip_select],
                            c.typed ? c.shown[31 - 8 * i -: 8] : digit_bytes[i],
                            i == DIGITS - 1});
                end
                default: ;
            endcase
        end
    endtask

    // called at a clock edge; leaves start high for a back-to-back request
    task automatic issue(input command_t c);
        begin
            start    <= 1'b1;
            kind     <= c.kind;
            position <= c.pos;
            value    <= c.val;
            do @(posedge clk); while (busy);
            track_command(c);
        end
    endtask

    task automatic hold_off(input int cycles);
        begin
            if (cycles > 0)
            begin
                start <= 1'b0;
                repeat (cycles) @(posedge clk);
            end
        end
    endtask

    task automatic wait_frames_done();
        begin
            start <= 1'b0;
            do @(posedge clk); while (pending_frame.size() != 0);
        end
    endtask

    task automatic drain();
        begin
            wait_frames_done();
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic select_chip(input logic [1:0] sel);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= sel;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            chip_select = sel;
        end
    endtask

    function automatic command_t random_command();
        command_t c;
        int       pick;
        begin
            c = '0;
            c.val = 16'($urandom);
            c.pos = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                c.kind = K_NUMBER;
                case ($urandom_range(0, 3))
                    0, 1: c.val = 16'($urandom_range(0, 9999));
                    2: c.val = 16'($urandom_range(9990, 10010));
                    default: ;
                endcase
            end
            else if (pick < 30)
            begin
                c.kind = K_DIGIT;
                if ($urandom_range(0, 2) != 0)
                    c.val[7:0] = 8'($urandom_range(0, 10));
            end
            else if (pick < 40) c.kind = K_DOT;
            else if (pick < 48) c.kind = K_MINUS;
            else if (pick < 58) c.kind = K_RAW;
            else if (pick < 62) c.kind = K_CLEAR_ALL;
            else if (pick < 70) c.kind = K_CLEAR_DIGIT;
            else c.kind = K_SEND;
            return c;
        end
    endfunction

    task automatic run_random(input int count);
        int  issued;
        int  burst;
        int  roll;
        bit  paused;
        begin
            issued = 0;
            paused = 1'b0;
            while (issued < count)
            begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst && issued < count; i++)
                begin
                    issue(random_command());
                    issued++;
                end
                roll = $urandom_range(0, 9);
                if (!paused && issued >= count / 2)
                begin
                    // let every queued frame come out before carrying on
                    paused = 1'b1;
                    wait_frames_done();
                end
                else if (roll < 4)
                    hold_off(0);
                else if (roll < 8)
                    hold_off($urandom_range(1, 4));
                else
                    hold_off($urandom_range(8, 20));
            end
        end
    endtask

    always @(posedge clk)
    begin : check_frames
        frame_entry_t want;
        if (rst_n && strobe)
        begin
            if (pending_frame.size() == 0)
            begin
                $error("frame byte %h with no request outstanding", frame_byte);
                errors++;
            end
            else
            begin
                want = pending_frame.pop_front();
                bytes_checked++;
                if (bus_address !== want.addr)
                begin
                    $error("bus_address: expected %h, got %h", want.addr, bus_address);
                    errors++;
                end
                if (frame_byte !== want.data)
                begin
                    $error("frame_byte: expected %h, got %h", want.data, frame_byte);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    errors++;
                end
            end
        end
    end

    command_t directed [24] = '{
        '{K_SEND,        3'd0, 16'h0000, 1'b1, 32'h00000000},
        '{K_NUMBER,      3'd5, 16'd0,    1'b0, 32'h0},
        '{K_SEND,        3'd0, 16'h0000, 1'b1, 32'h3F3F3F3F},
        '{K_NUMBER,      3'd0, 16'hFFFF, 1'b0, 32'h0},
        '{K_SEND,        3'd7, 16'h0000, 1'b1, 32'h6F6F6F6F},
        '{K_NUMBER,      3'd2, 16'd1234, 1'b0, 32'h0},
        '{K_DOT,         3'd3, 16'h0000, 1'b0, 32'h0},
        '{K_DIGIT,       3'd0, 16'h00FF, 1'b0, 32'h0},
        '{K_DIGIT,       3'd3, 16'hA505, 1'b0, 32'h0},
        '{K_MINUS,       3'd1, 16'h0000, 1'b0, 32'h0},
        '{K_RAW,         3'd2, 16'hFFFF, 1'b0, 32'h0},
        '{K_SEND,        3'd0, 16'h0000, 1'b0, 32'h0},
        '{K_DIGIT,       3'd7, 16'h0003, 1'b0, 32'h0},
        '{K_MINUS,       3'd4, 16'h0000, 1'b0, 32'h0},
        '{K_RAW,         3'd5, 16'h0012, 1'b0, 32'h0},
        '{K_CLEAR_DIGIT, 3'd6, 16'h0000, 1'b0, 32'h0},
        '{K_SEND,        3'd0, 16'h0000, 1'b0, 32'h0},
        '{K_DOT,         3'd7, 16'h0000, 1'b0, 32'h0},
        '{K_CLEAR_DIGIT, 3'd2, 16'h0000, 1'b0, 32'h0},
        '{K_SEND,        3'd0, 16'h0000, 1'b0, 32'h0},
        '{K_RAW,         3'd0, 16'h0080, 1'b0, 32'h0},
        '{K_CLEAR_ALL,   3'd0, 16'h0000, 1'b0, 32'h0},
        '{K_NUMBER,      3'd0, 16'd9999, 1'b0, 32'h0},
        '{K_SEND,        3'd0, 16'h0000, 1'b1, 32'h6F6F6F6F}
    };

    initial
    begin
        errors          = 0;
        commands_issued = 0;
        sends_issued    = 0;
        bytes_checked   = 0;
        chip_select     = 2'd0;
        for (int i = 0; i < DIGITS; i++)
            digit_bytes[i] = 8'h00;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        select_chip(2'd3);
        foreach (directed[i])
        begin
            issue(directed[i]);
            hold_off($urandom_range(0, 2));
        end
        drain();

        select_chip(2'd0);
        run_random(52);
        drain();
        select_chip(2'd1);
        run_random(52);
        drain();
        select_chip(2'd2);
        run_random(51);
        drain();
        select_chip(2'd3);
        run_random(51);
        drain();

        $display("%0d requests issued, %0d of them sends, %0d frame bytes compared",
                 commands_issued, sends_issued, bytes_checked);
        $display("all four chip addresses and every command kind exercised");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
